FILE: hdl/sbl_pkg.sv
package sbl_pkg;

  // Field widths of the item and result words
  localparam int ACTION_W = 2;
  localparam int BIN_W    = 11;
  localparam int SLOT_W   = 12;
  localparam int VALUE_W  = 16;
  localparam int ID_W     = 16;
  localparam int RANGE_W  = 13;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WR_OFS = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_ID  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFS1,
    S_OFS2,
    S_TREAD,
    S_TDATA,
    S_CDATA,
    S_DECIDE,
    S_BS,
    S_BSCMP,
    S_SHIFT,
    S_FIX,
    S_FIX2,
    S_DONE
  } state_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] range_begin;
    logic [RANGE_W-1:0] range_end;
    logic               bin_emptied;
  } resp_t;

endpackage

FILE: hdl/sbl_ram.sv
module sbl_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and read one word; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sbl_ctrl.sv
module sbl_ctrl #(
  parameter int          STORE_SLOTS = 4096,
  parameter int          BIN_COUNT   = 1024,
  parameter logic [32:0] ID_LIMIT    = 33'd65534,
  parameter int          STORE_AW    = $clog2(STORE_SLOTS),
  parameter int          OFS_W       = $clog2(STORE_SLOTS + 1),
  parameter int          OFS_AW      = $clog2(BIN_COUNT + 1),
  parameter int          FLG_AW      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbl_pkg::ACTION_W-1:0] in_action,
  input  logic [sbl_pkg::BIN_W-1:0]    in_bin_index,
  input  logic [sbl_pkg::SLOT_W-1:0]   in_slot,
  input  logic [sbl_pkg::VALUE_W-1:0]  in_write_value,
  input  logic [sbl_pkg::ID_W-1:0]     in_remove_id,
  // result toward the output register
  output sbl_pkg::resp_t               resp,
  input  logic                         resp_take,
  // offset table
  output logic                         ofs_we,
  output logic [OFS_AW-1:0]            ofs_waddr,
  output logic [OFS_W-1:0]             ofs_wdata,
  output logic [OFS_AW-1:0]            ofs_raddr,
  input  logic [OFS_W-1:0]             ofs_rdata,
  // identifier store
  output logic                         st_we,
  output logic [STORE_AW-1:0]          st_waddr,
  output logic [sbl_pkg::ID_W-1:0]     st_wdata,
  output logic [STORE_AW-1:0]          st_raddr,
  input  logic [sbl_pkg::ID_W-1:0]     st_rdata,
  // empty flags
  output logic                         flg_we,
  output logic [FLG_AW-1:0]            flg_waddr,
  output logic                         flg_wdata,
  output logic [FLG_AW-1:0]            flg_raddr,
  input  logic                         flg_rdata
);

  localparam logic [FLG_AW-1:0] CLR_LAST = FLG_AW'(BIN_COUNT - 1);

  sbl_pkg::state_t                state_r, state_nxt;
  logic [FLG_AW-1:0]              clr_r, clr_nxt;
  logic [sbl_pkg::ACTION_W-1:0]   act_r, act_nxt;
  logic [sbl_pkg::BIN_W-1:0]      bin_r, bin_nxt;
  logic [sbl_pkg::ID_W-1:0]       rid_r, rid_nxt;
  logic [OFS_W-1:0]               beg_r, beg_nxt;
  logic [OFS_W-1:0]               bend_r, bend_nxt;
  logic [OFS_W-1:0]               end_r, end_nxt;
  logic [OFS_W-1:0]               lo_r, lo_nxt;
  logic [OFS_W-1:0]               hi_r, hi_nxt;
  logic [OFS_W-1:0]               idx_r, idx_nxt;
  logic [STORE_AW-1:0]            mid_r, mid_nxt;
  logic [sbl_pkg::ID_W-1:0]       tail_r, tail_nxt;
  logic [sbl_pkg::ID_W-1:0]       cnt_r, cnt_nxt;
  logic                           flag_r, flag_nxt;
  logic                           emptied_r, emptied_nxt;
  logic [OFS_W-1:0]               mid_full;
  logic [OFS_W-1:0]               room;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbl_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    bin_r     <= bin_nxt;
    rid_r     <= rid_nxt;
    beg_r     <= beg_nxt;
    bend_r    <= bend_nxt;
    end_r     <= end_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    idx_r     <= idx_nxt;
    mid_r     <= mid_nxt;
    tail_r    <= tail_nxt;
    cnt_r     <= cnt_nxt;
    flag_r    <= flag_nxt;
    emptied_r <= emptied_nxt;
  end

  // Shared search and bound arithmetic
  assign mid_full = lo_r + ((hi_r - lo_r) >> 1);
  assign room     = bend_r - beg_r - OFS_W'(2);

  // Hand the finished word to the output register
  assign in_stall              = (state_r != sbl_pkg::S_IDLE);
  assign resp.valid            = (state_r == sbl_pkg::S_DONE);
  assign resp.range_begin      = sbl_pkg::RANGE_W'(beg_r);
  assign resp.range_end        = sbl_pkg::RANGE_W'(end_r);
  assign resp.bin_emptied      = emptied_r;

  // Sequencer: next state and memory controls
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    act_nxt     = act_r;
    bin_nxt     = bin_r;
    rid_nxt     = rid_r;
    beg_nxt     = beg_r;
    bend_nxt    = bend_r;
    end_nxt     = end_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    idx_nxt     = idx_r;
    mid_nxt     = mid_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    flag_nxt    = flag_r;
    emptied_nxt = emptied_r;
    ofs_we      = 1'b0;
    ofs_waddr   = OFS_AW'(in_bin_index);
    ofs_wdata   = '0;
    ofs_raddr   = OFS_AW'(in_bin_index);
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = '0;
    st_raddr    = '0;
    flg_we      = 1'b0;
    flg_waddr   = FLG_AW'(in_bin_index);
    flg_wdata   = 1'b0;
    flg_raddr   = FLG_AW'(in_bin_index);

    unique case (state_r)
      // Sweep the empty flags to zero after reset
      sbl_pkg::S_CLEAR: begin
        flg_we    = 1'b1;
        flg_waddr = clr_r;
        clr_nxt   = clr_r + FLG_AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = sbl_pkg::S_IDLE;
        end
      end

      // Take a word; loads finish here, lookups start reading the bin offset
      sbl_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          bin_nxt     = in_bin_index;
          rid_nxt     = in_remove_id;
          beg_nxt     = '0;
          end_nxt     = '0;
          emptied_nxt = 1'b0;
          state_nxt   = sbl_pkg::S_DONE;
          unique case (in_action)
            sbl_pkg::ACT_WR_OFS: begin
              if (32'(in_bin_index) <= 32'(BIN_COUNT)) begin
                ofs_we = 1'b1;
                if (32'(in_write_value) > 32'(STORE_SLOTS)) begin
                  ofs_wdata = OFS_W'(STORE_SLOTS);
                end else begin
                  ofs_wdata = OFS_W'(in_write_value);
                end
              end
              if (32'(in_bin_index) < 32'(BIN_COUNT)) begin
                flg_we = 1'b1;
              end
            end
            sbl_pkg::ACT_WR_ID: begin
              if (32'(in_slot) < 32'(STORE_SLOTS)) begin
                st_we    = 1'b1;
                st_waddr = STORE_AW'(in_slot);
                st_wdata = in_write_value;
              end
            end
            sbl_pkg::ACT_FIND, sbl_pkg::ACT_REMOVE: begin
              if (32'(in_bin_index) < 32'(BIN_COUNT)) begin
                state_nxt = sbl_pkg::S_OFS1;
              end
            end
            default: ;
          endcase
        end
      end

      // Capture begin offset and flag, read end offset
      sbl_pkg::S_OFS1: begin
        ofs_raddr = OFS_AW'(bin_r) + OFS_AW'(1);
        beg_nxt   = ofs_rdata;
        flag_nxt  = flg_rdata;
        state_nxt = sbl_pkg::S_OFS2;
      end

      sbl_pkg::S_OFS2: begin
        bend_nxt  = ofs_rdata;
        end_nxt   = beg_r;
        state_nxt = sbl_pkg::S_TREAD;
      end

      // Empty, flagged or reversed bin ends here; otherwise fetch the tail marker
      sbl_pkg::S_TREAD: begin
        if (!(beg_r < bend_r) || flag_r) begin
          state_nxt = sbl_pkg::S_DONE;
        end else begin
          st_raddr  = STORE_AW'(bend_r - OFS_W'(1));
          state_nxt = sbl_pkg::S_TDATA;
        end
      end

      // Decode the tail marker
      sbl_pkg::S_TDATA: begin
        tail_nxt  = st_rdata;
        state_nxt = sbl_pkg::S_DECIDE;
        if ({17'd0, st_rdata} == ID_LIMIT) begin
          end_nxt = bend_r - OFS_W'(1);
        end else if ({17'd0, st_rdata} == ID_LIMIT + 33'd1) begin
          if ((bend_r - beg_r) >= OFS_W'(2)) begin
            st_raddr  = STORE_AW'(bend_r - OFS_W'(2));
            state_nxt = sbl_pkg::S_CDATA;
          end
        end else begin
          end_nxt = bend_r;
        end
      end

      // Clamp the count word to the room before it
      sbl_pkg::S_CDATA: begin
        cnt_nxt = st_rdata;
        if (32'(st_rdata) < 32'(room)) begin
          end_nxt = beg_r + OFS_W'(st_rdata);
        end else begin
          end_nxt = bend_r - OFS_W'(2);
        end
        state_nxt = sbl_pkg::S_DECIDE;
      end

      // Finish a find, drop a lone entry, or start the search
      sbl_pkg::S_DECIDE: begin
        state_nxt = sbl_pkg::S_DONE;
        if (act_r == sbl_pkg::ACT_REMOVE && end_r > beg_r) begin
          if ((end_r - beg_r) == OFS_W'(1)) begin
            flg_we      = 1'b1;
            flg_waddr   = FLG_AW'(bin_r);
            flg_wdata   = 1'b1;
            end_nxt     = beg_r;
            emptied_nxt = 1'b1;
          end else begin
            lo_nxt    = beg_r;
            hi_nxt    = end_r;
            state_nxt = sbl_pkg::S_BS;
          end
        end
      end

      // Probe the midpoint, or start the shift at the lower bound
      sbl_pkg::S_BS: begin
        if (lo_r < hi_r) begin
          mid_nxt   = STORE_AW'(mid_full);
          st_raddr  = STORE_AW'(mid_full);
          state_nxt = sbl_pkg::S_BSCMP;
        end else begin
          idx_nxt = lo_r;
          if (lo_r + OFS_W'(1) < end_r) begin
            st_raddr  = STORE_AW'(lo_r + OFS_W'(1));
            state_nxt = sbl_pkg::S_SHIFT;
          end else begin
            state_nxt = sbl_pkg::S_FIX;
          end
        end
      end

      // Narrow the search window
      sbl_pkg::S_BSCMP: begin
        if (st_rdata < rid_r) begin
          lo_nxt = OFS_W'(mid_r) + OFS_W'(1);
        end else begin
          hi_nxt = OFS_W'(mid_r);
        end
        state_nxt = sbl_pkg::S_BS;
      end

      // Move one entry down per cycle, reading ahead by one
      sbl_pkg::S_SHIFT: begin
        st_we    = 1'b1;
        st_waddr = STORE_AW'(idx_r);
        st_wdata = st_rdata;
        idx_nxt  = idx_r + OFS_W'(1);
        if (idx_r + OFS_W'(2) < end_r) begin
          st_raddr = STORE_AW'(idx_r + OFS_W'(2));
        end else begin
          state_nxt = sbl_pkg::S_FIX;
        end
      end

      // Rewrite the marker or the count word
      sbl_pkg::S_FIX: begin
        end_nxt   = end_r - OFS_W'(1);
        st_we     = 1'b1;
        state_nxt = sbl_pkg::S_DONE;
        if (end_r == bend_r) begin
          st_waddr = STORE_AW'(bend_r - OFS_W'(1));
          st_wdata = sbl_pkg::ID_W'(ID_LIMIT);
        end else if ({17'd0, tail_r} == ID_LIMIT) begin
          st_waddr  = STORE_AW'(bend_r - OFS_W'(1));
          st_wdata  = sbl_pkg::ID_W'(ID_LIMIT + 33'd1);
          state_nxt = sbl_pkg::S_FIX2;
        end else begin
          st_waddr = STORE_AW'(bend_r - OFS_W'(2));
          st_wdata = cnt_r - sbl_pkg::ID_W'(1);
        end
      end

      // Store the new live count after converting to the count form
      sbl_pkg::S_FIX2: begin
        st_we     = 1'b1;
        st_waddr  = STORE_AW'(bend_r - OFS_W'(2));
        st_wdata  = sbl_pkg::ID_W'(end_r - beg_r);
        state_nxt = sbl_pkg::S_DONE;
      end

      // Hold the result until the output register takes it
      sbl_pkg::S_DONE: begin
        if (resp_take) begin
          state_nxt = sbl_pkg::S_IDLE;
        end
      end

      default: state_nxt = sbl_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hdl/sorted_bin_lookup_and_remove_core.sv
// Sorted-bin identifier store with lookup and removal. Bins of a flat 16-bit
// identifier store are delimited by an offset table; action 0 loads an offset,
// action 1 loads a store slot, action 2 returns a bin's live range and action 3
// removes an identifier (lower-bound position) and returns the shortened range.
// One item is worked on at a time; every item gives exactly one result word.
// Loads and out-of-range bins finish from idle; a find reads the bin offsets,
// the empty flag, the tail marker and, for a count marker, the count word; a
// remove adds a binary search and a shift of the later entries. The single
// port pair of the identifier store paces both: the binary search spends a
// read and a compare per step, the shift moves one entry per cycle. A result
// waiting at the output does not hold off the next item. After reset the block
// sweeps the empty flags to zero before it takes the first item.
module sorted_bin_lookup_and_remove_core #(
  parameter int          STORE_SLOTS = 4096,
  parameter int          BIN_COUNT   = 1024,
  parameter logic [32:0] ID_LIMIT    = 33'd65534
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbl_pkg::ACTION_W-1:0] in_action,
  input  logic [sbl_pkg::BIN_W-1:0]    in_bin_index,
  input  logic [sbl_pkg::SLOT_W-1:0]   in_slot,
  input  logic [sbl_pkg::VALUE_W-1:0]  in_write_value,
  input  logic [sbl_pkg::ID_W-1:0]     in_remove_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sbl_pkg::RANGE_W-1:0]  out_range_begin,
  output logic [sbl_pkg::RANGE_W-1:0]  out_range_end,
  output logic                         out_bin_emptied
);

  localparam int STORE_AW = $clog2(STORE_SLOTS);
  localparam int OFS_W    = $clog2(STORE_SLOTS + 1);
  localparam int OFS_AW   = $clog2(BIN_COUNT + 1);
  localparam int FLG_AW   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  sbl_pkg::resp_t              resp;
  logic                        resp_take;
  logic                        ofs_we;
  logic [OFS_AW-1:0]           ofs_waddr;
  logic [OFS_W-1:0]            ofs_wdata;
  logic [OFS_AW-1:0]           ofs_raddr;
  logic [OFS_W-1:0]            ofs_rdata;
  logic                        st_we;
  logic [STORE_AW-1:0]         st_waddr;
  logic [sbl_pkg::ID_W-1:0]    st_wdata;
  logic [STORE_AW-1:0]         st_raddr;
  logic [sbl_pkg::ID_W-1:0]    st_rdata;
  logic                        flg_we;
  logic [FLG_AW-1:0]           flg_waddr;
  logic                        flg_wdata;
  logic [FLG_AW-1:0]           flg_raddr;
  logic                        flg_rdata;
  logic                        out_valid_r;
  logic [sbl_pkg::RANGE_W-1:0] out_begin_r;
  logic [sbl_pkg::RANGE_W-1:0] out_end_r;
  logic                        out_emptied_r;

  // Bin offset table
  sbl_ram #(.WIDTH(OFS_W), .DEPTH(BIN_COUNT + 1), .ADDR_W(OFS_AW)) u_ofs_ram (
    .clk   (clk),
    .we    (ofs_we),
    .waddr (ofs_waddr),
    .wdata (ofs_wdata),
    .raddr (ofs_raddr),
    .rdata (ofs_rdata)
  );

  // Identifier store
  sbl_ram #(.WIDTH(sbl_pkg::ID_W), .DEPTH(STORE_SLOTS), .ADDR_W(STORE_AW)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Per-bin empty flags
  sbl_ram #(.WIDTH(1), .DEPTH(BIN_COUNT), .ADDR_W(FLG_AW)) u_flg_ram (
    .clk   (clk),
    .we    (flg_we),
    .waddr (flg_waddr),
    .wdata (flg_wdata),
    .raddr (flg_raddr),
    .rdata (flg_rdata)
  );

  sbl_ctrl #(
    .STORE_SLOTS (STORE_SLOTS),
    .BIN_COUNT   (BIN_COUNT),
    .ID_LIMIT    (ID_LIMIT),
    .STORE_AW    (STORE_AW),
    .OFS_W       (OFS_W),
    .OFS_AW      (OFS_AW),
    .FLG_AW      (FLG_AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_bin_index   (in_bin_index),
    .in_slot        (in_slot),
    .in_write_value (in_write_value),
    .in_remove_id   (in_remove_id),
    .resp           (resp),
    .resp_take      (resp_take),
    .ofs_we         (ofs_we),
    .ofs_waddr      (ofs_waddr),
    .ofs_wdata      (ofs_wdata),
    .ofs_raddr      (ofs_raddr),
    .ofs_rdata      (ofs_rdata),
    .st_we          (st_we),
    .st_waddr       (st_waddr),
    .st_wdata       (st_wdata),
    .st_raddr       (st_raddr),
    .st_rdata       (st_rdata),
    .flg_we         (flg_we),
    .flg_waddr      (flg_waddr),
    .flg_wdata      (flg_wdata),
    .flg_raddr      (flg_raddr),
    .flg_rdata      (flg_rdata)
  );

  // Load the output register when it is empty or being drained
  assign resp_take = resp.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_take) begin
      out_begin_r   <= resp.range_begin;
      out_end_r     <= resp.range_end;
      out_emptied_r <= resp.bin_emptied;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_begin = out_begin_r;
  assign out_range_end   = out_end_r;
  assign out_bin_emptied = out_emptied_r;

  // A live range never runs backward
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_range_end >= out_range_begin)
    else $error("result range ends before it begins");

  // An emptied bin reports an empty range
  a_emptied_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bin_emptied) |-> out_range_end == out_range_begin)
    else $error("emptied bin with a non-empty range");

  // No new word is taken while a result is pending inside
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    resp.valid |-> in_stall)
    else $error("word accepted while a result is pending");

  // A handed-over result shows at the output next cycle
  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    resp_take |=> out_valid)
    else $error("taken result missing at the output");

endmodule
